// File: sv/hsv_fade_color_generator_core_defines.svh
// Assertion macros shared by the checker of the HSV fade color generator.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HSV_FADE_COLOR_GENERATOR_CORE_DEFINES_SVH
`define HSV_FADE_COLOR_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define HFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hfc_checker: same-cycle property failed");

// Next-cycle implication, ignored while reset is high.
`define HFC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hfc_checker: next-cycle property failed");

// Same-cycle implication that is also checked around reset.
`define HFC_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("hfc_checker: reset property failed");

`endif

// File: sv/hfc_pkg.sv
// Package of the HSV fade color generator: shared types, constants and helpers.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hfc_pkg;

  // Request kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  // Register map (word index) and reset values.
  localparam int unsigned REG_FADE_INTERVAL   = 0;
  localparam logic [7:0]  FADE_INTERVAL_RESET = 8'd4;
  localparam logic [7:0]  TGT_VAL_RESET       = 8'd255;
  localparam logic [7:0]  COUNT_MAX           = 8'd255;

  // Hue geometry: six sectors of forty steps.
  localparam logic [7:0]  HUE_MAX      = 8'd239;
  localparam logic [7:0]  SECTOR_WIDTH = 8'd40;

  // Division by five as a multiply by ceil(2^18 / 5) and a shift.
  localparam logic [15:0] RECIP_5     = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 18;

  typedef struct packed {
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
  } hsv_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_PROD,
    CV_QUOT,
    CV_NPROD,
    CV_LOAD
  } cv_state_t;

  // Sector index of a hue that has already been clamped to HUE_MAX.
  function automatic logic [2:0] sector_of(input logic [7:0] h);
    logic [2:0] sec;
    if (h >= 8'd200) begin
      sec = 3'd5;
    end else if (h >= 8'd160) begin
      sec = 3'd4;
    end else if (h >= 8'd120) begin
      sec = 3'd3;
    end else if (h >= 8'd80) begin
      sec = 3'd2;
    end else if (h >= 8'd40) begin
      sec = 3'd1;
    end else begin
      sec = 3'd0;
    end
    return sec;
  endfunction

endpackage

`default_nettype wire

// File: sv/hfc_front.sv
// Front end of the HSV fade color generator: request intake, target and fade state.
// Uses hfc_pkg; pushes each stepped HSV color into the result queue.
`default_nettype none

module hfc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            kind,
  input  wire logic [7:0]      hue_in,
  input  wire logic [7:0]      sat_in,
  input  wire logic [7:0]      val_in,
  input  wire logic [7:0]      fade_interval,
  input  wire hfc_pkg::q_status_t q_stat,
  output logic                 q_push,
  output hfc_pkg::hsv_t        q_data
);

  hfc_pkg::hsv_t cur, cur_next;
  hfc_pkg::hsv_t tgt;
  logic [7:0]    tick_count, tick_count_next;
  logic [7:0]    count;
  logic          accept;
  logic          fire;

  function automatic logic [7:0] step_toward(input logic [7:0] now, input logic [7:0] goal);
    logic [7:0] r;
    if (now < goal) begin
      r = now + 8'd1;
    end else if (now > goal) begin
      r = now - 8'd1;
    end else begin
      r = now;
    end
    return r;
  endfunction

  // A request can always be taken while the queue has room for its result.
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    count           = (tick_count == hfc_pkg::COUNT_MAX) ? tick_count : tick_count + 8'd1;
    fire            = 1'b0;
    tick_count_next = tick_count;
    cur_next.h      = step_toward(cur.h, tgt.h);
    cur_next.s      = step_toward(cur.s, tgt.s);
    cur_next.v      = step_toward(cur.v, tgt.v);
    if (accept && kind == hfc_pkg::KIND_TICK) begin
      if (count <= fade_interval) begin
        tick_count_next = count;
      end else begin
        tick_count_next = 8'd0;
        fire            = (cur != tgt);
      end
    end
  end

  assign q_push = fire;
  assign q_data = cur_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      tgt.h      <= 8'd0;
      tgt.s      <= 8'd0;
      tgt.v      <= hfc_pkg::TGT_VAL_RESET;
      tick_count <= 8'd0;
    end else begin
      tick_count <= tick_count_next;
      if (fire) begin
        cur <= cur_next;
      end
      if (accept && kind == hfc_pkg::KIND_SET) begin
        tgt.h <= (hue_in > hfc_pkg::HUE_MAX) ? hfc_pkg::HUE_MAX : hue_in;
        tgt.s <= sat_in;
        tgt.v <= val_in;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/hfc_queue.sv
// Short FIFO of stepped HSV colors between the front end and the converter.
// Uses hfc_pkg for the entry and status types.
`default_nettype none

module hfc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire hfc_pkg::hsv_t  wdata,
  input  wire logic           pop,
  output hfc_pkg::hsv_t       rdata,
  output hfc_pkg::q_status_t  stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  hfc_pkg::hsv_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign stat.full  = (fill == FULL);
  assign stat.empty = (fill == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/hfc_convert.sv
// Back end of the HSV fade color generator: six-sector HSV to RGB conversion.
// Uses hfc_pkg; pops from the result queue and drives the output register.
`default_nettype none

module hfc_convert (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hfc_pkg::q_status_t q_stat,
  input  wire hfc_pkg::hsv_t      q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue
);

  hfc_pkg::cv_state_t state, state_next;
  hfc_pkg::hsv_t      item;
  logic               load;
  logic [2:0]         sector;
  logic [15:0]        m_prod;
  logic [13:0]        sf_prod;
  logic [7:0]         quot;
  logic [15:0]        n_prod;

  logic [7:0]  h_clamped;
  logic [2:0]  sector_c;
  logic [7:0]  frac_raw;
  logic [5:0]  frac;
  logic [26:0] quot_wide;
  logic [7:0]  m, n;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      hfc_pkg::CV_IDLE:  if (!q_stat.empty) state_next = hfc_pkg::CV_PROD;
      hfc_pkg::CV_PROD:  state_next = hfc_pkg::CV_QUOT;
      hfc_pkg::CV_QUOT:  state_next = hfc_pkg::CV_NPROD;
      hfc_pkg::CV_NPROD: state_next = hfc_pkg::CV_LOAD;
      hfc_pkg::CV_LOAD:  if (!out_valid || out_ready) state_next = hfc_pkg::CV_IDLE;
      default:           state_next = hfc_pkg::CV_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop = 1'b0;
    load  = 1'b0;
    unique case (state)
      hfc_pkg::CV_IDLE: q_pop = !q_stat.empty;
      hfc_pkg::CV_LOAD: load  = !out_valid || out_ready;
      default: begin
        q_pop = 1'b0;
        load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hfc_pkg::CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sector and fraction of the hue; even sectors count the fraction downward.
  always_comb begin
    h_clamped = (item.h > hfc_pkg::HUE_MAX) ? hfc_pkg::HUE_MAX : item.h;
    sector_c  = hfc_pkg::sector_of(h_clamped);
    frac_raw  = h_clamped - 8'(sector_c * hfc_pkg::SECTOR_WIDTH);
    if (!sector_c[0]) begin
      frac = 6'(hfc_pkg::SECTOR_WIDTH - frac_raw);
    end else begin
      frac = frac_raw[5:0];
    end
  end

  // s*f/40 is (s*f/8)/5; the reciprocal is exact for every value that fits here.
  assign quot_wide = {16'd0, sf_prod[13:3]} * {11'd0, hfc_pkg::RECIP_5};
  assign m = m_prod[15:8];
  assign n = n_prod[15:8];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_data;
    end
    if (state == hfc_pkg::CV_PROD) begin
      sector  <= sector_c;
      m_prod  <= {8'd0, item.v} * {8'd0, ~item.s};
      sf_prod <= {6'd0, item.s} * {8'd0, frac};
    end
    if (state == hfc_pkg::CV_QUOT) begin
      quot <= quot_wide[hfc_pkg::RECIP_SHIFT +: 8];
    end
    if (state == hfc_pkg::CV_NPROD) begin
      n_prod <= {8'd0, item.v} * {8'd0, 8'd255 - quot};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      case (sector)
        3'd0:    begin red <= item.v; green <= n;      blue <= m;      end
        3'd1:    begin red <= n;      green <= item.v; blue <= m;      end
        3'd2:    begin red <= m;      green <= item.v; blue <= n;      end
        3'd3:    begin red <= m;      green <= n;      blue <= item.v; end
        3'd4:    begin red <= n;      green <= m;      blue <= item.v; end
        default: begin red <= item.v; green <= m;      blue <= n;      end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sv/hsv_fade_color_generator_core.sv
// Top level of the HSV fade color generator: APB register, front end, queue, converter.
// Depends on hfc_pkg, hfc_front, hfc_queue and hfc_convert.
//
// Usage. Requests arrive on the input channel (in_valid/in_ready) with kind, hue_in,
// sat_in and val_in. A request of kind set-target stores a new target color, with the
// hue clamped to 239. A tick request advances the tick counter; when the counter passes
// fade_interval it restarts, and if the current color differs from the target, hue,
// saturation and value each move one step toward it. Each such step produces one RGB
// result on the output channel (out_valid/out_ready with red, green and blue).
// The front end takes one request per cycle while the result queue has room. The converter
// works on one step at a time and pops the next step only from its idle state; it goes
// through the pop, two products, the reciprocal divide by forty, a third product, then
// the output load, which waits while a result in the output register is not taken.
// If the receiver stalls, the result stays in the output register, the converter waits
// with the next step, the queue fills, and in_ready falls once it is full.
// The fade_interval register sits at byte address 0 of the APB port and resets to 4.
// Synchronous reset clears the queue and output valid, sets the current color to black,
// the target to hue 0, saturation 0, value 255, and the tick counter to zero.
`default_nettype none

module hsv_fade_color_generator_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [7:0]  hue_in,
  input  wire logic [7:0]  sat_in,
  input  wire logic [7:0]  val_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]          fade_interval;
  logic                q_push, q_pop;
  hfc_pkg::hsv_t       q_wdata, q_rdata;
  hfc_pkg::q_status_t  q_stat;
  logic                cfg_write;
  logic [1:0]          word_index;

  // The single register fills the whole two-bit address space, so every word index
  // decodes to it; the byte offset within the word is not used.
  assign pready     = 1'b1;
  assign word_index = 2'(paddr >> 2);
  assign cfg_write  = psel && penable && pwrite && pready &&
                      (32'(word_index) == hfc_pkg::REG_FADE_INTERVAL);
  assign prdata     = {24'd0, fade_interval};

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_interval <= hfc_pkg::FADE_INTERVAL_RESET;
    end else if (cfg_write) begin
      fade_interval <= pwdata[7:0];
    end
  end

  hfc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .hue_in        (hue_in),
    .sat_in        (sat_in),
    .val_in        (val_in),
    .fade_interval (fade_interval),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  hfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  hfc_convert u_convert (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

`default_nettype wire

// File: sv/hfc_checker.sv
// Port-level checker of the HSV fade color generator, bound to the top level.
// Depends on hsv_fade_color_generator_core_defines.svh for its assertion macros.
`default_nettype none
`include "hsv_fade_color_generator_core_defines.svh"

module hfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  red,
  input wire logic [7:0]  green,
  input wire logic [7:0]  blue,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);

  // A stalled result stays offered and unchanged.
  `HFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `HFC_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable({red, green, blue}))

  // Right after reset nothing is pending and requests are taken.
  `HFC_ASSERT_ALWAYS(a_reset_idle, $past(rst) && !rst, !out_valid && in_ready)

  // A register write reads back on the next cycle.
  `HFC_ASSERT_NXT(a_cfg_readback, psel && penable && pwrite, prdata == {24'd0, $past(pwdata[7:0])})

endmodule

bind hsv_fade_color_generator_core hfc_checker u_hfc_checker (.*);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for hsv_fade_color_generator_core: it drives set-target and tick
// requests, models the fade and the HSV to RGB conversion, and checks every RGB result.
// Depends on hfc_pkg and on the RTL of the block.

module tb_top;

  localparam int unsigned CH_MAX        = 255;
  localparam int unsigned CH_SCALE      = 256;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned RANDOM_ITEMS  = 360;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = hfc_pkg::KIND_TICK;
  logic [7:0]  hue_in = '0;
  logic [7:0]  sat_in = '0;
  logic [7:0]  val_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the fader state, advanced once per accepted request.
  hfc_pkg::hsv_t cur_color;
  hfc_pkg::hsv_t tgt_color;
  logic [7:0]    tick_cnt;
  logic [7:0]    fade_int;

  // RGB values of fade steps that are still on their way out of the block.
  rgb_t rgb_expected[$];

  bit          idle_en = 1'b0;
  logic        hold_off = 1'b0;
  int unsigned stall_left = 0;
  int unsigned err_cnt = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_input_stalls = 0;
  event        hold_go;

  hsv_fade_color_generator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .hue_in    (hue_in),
    .sat_in    (sat_in),
    .val_in    (val_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Integer six-sector conversion. Even sectors count the fraction down from the
  // sector width so that the mixed channel rises as the hue moves up through the sector.
  function automatic rgb_t hsv_to_rgb(hfc_pkg::hsv_t c);
    int unsigned hh, sec, frac, vv, ss, lo, mid;
    rgb_t o;
    hh = (c.h > hfc_pkg::HUE_MAX) ? hfc_pkg::HUE_MAX : c.h;
    sec = hh / hfc_pkg::SECTOR_WIDTH;
    frac = hh - sec * hfc_pkg::SECTOR_WIDTH;
    if (sec % 2 == 0) begin
      frac = hfc_pkg::SECTOR_WIDTH - frac;
    end
    vv = c.v;
    ss = c.s;
    lo = (vv * (CH_MAX - ss)) / CH_SCALE;
    mid = (vv * (CH_MAX - (ss * frac) / hfc_pkg::SECTOR_WIDTH)) / CH_SCALE;
    case (sec)
      0: begin
        o = '{8'(vv), 8'(mid), 8'(lo)};
      end
      1: begin
        o = '{8'(mid), 8'(vv), 8'(lo)};
      end
      2: begin
        o = '{8'(lo), 8'(vv), 8'(mid)};
      end
      3: begin
        o = '{8'(lo), 8'(mid), 8'(vv)};
      end
      4: begin
        o = '{8'(mid), 8'(lo), 8'(vv)};
      end
      default: begin
        o = '{8'(vv), 8'(lo), 8'(mid)};
      end
    endcase
    return o;
  endfunction

  function automatic logic [7:0] step_toward(logic [7:0] now, logic [7:0] goal);
    if (now < goal) begin
      return now + 8'd1;
    end else if (now > goal) begin
      return now - 8'd1;
    end
    return now;
  endfunction

  // Applies one accepted request to the shadow state and queues the RGB value of a
  // fade step when the request causes one.
  function automatic void advance_fader(logic k, logic [7:0] h, logic [7:0] s,
                                        logic [7:0] v);
    logic [7:0] cnt;
    if (k == hfc_pkg::KIND_SET) begin
      tgt_color.h = (h > hfc_pkg::HUE_MAX) ? hfc_pkg::HUE_MAX : h;
      tgt_color.s = s;
      tgt_color.v = v;
    end else begin
      cnt = tick_cnt;
      if (cnt < hfc_pkg::COUNT_MAX) begin
        cnt = cnt + 8'd1;
      end
      if (cnt <= fade_int) begin
        tick_cnt = cnt;
      end else begin
        tick_cnt = '0;
        if (cur_color != tgt_color) begin
          cur_color.h = step_toward(cur_color.h, tgt_color.h);
          cur_color.s = step_toward(cur_color.s, tgt_color.s);
          cur_color.v = step_toward(cur_color.v, tgt_color.v);
          rgb_expected.push_back(hsv_to_rgb(cur_color));
        end
      end
    end
  endfunction

  // Offers one request and returns right after the edge that accepts it. It is always
  // entered just after a rising edge, so valid is only lowered when a gap is taken.
  task automatic send_request(logic k, logic [7:0] h, logic [7:0] s, logic [7:0] v);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    hue_in <= h;
    sat_in <= s;
    val_in <= v;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    advance_fader(k, h, s, v);
    n_requests++;
  endtask

  task automatic send_ticks(int unsigned count);
    repeat (count) send_request(hfc_pkg::KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Stops offering requests, waits for every pending RGB result, then lets a tick that
  // caused no result work its way through the front end.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (rgb_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase register write; the register takes the value at the access edge.
  task automatic write_fade_interval(logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(hfc_pkg::REG_FADE_INTERVAL * 4);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fade_int = value;
  endtask

  // The result side: checks each accepted result against the oldest expectation and
  // decides the next value of out_ready, including random stalls and the long hold.
  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (rgb_expected.size() == 0) begin
          $error("unexpected RGB result %0d %0d %0d", red, green, blue);
          err_cnt++;
        end else begin
          want = rgb_expected.pop_front();
          if (red !== want.r) begin
            $error("red: expected %0d, actual %0d", want.r, red);
            err_cnt++;
          end
          if (green !== want.g) begin
            $error("green: expected %0d, actual %0d", want.g, green);
            err_cnt++;
          end
          if (blue !== want.b) begin
            $error("blue: expected %0d, actual %0d", want.b, blue);
            err_cnt++;
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 6);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender can keep offering ticks meanwhile.
  always begin
    @(hold_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready) begin
      n_input_stalls++;
    end
  end

  // Reset values: the first fade step only comes on the fifth tick at the default
  // interval, and it steps value up from black toward the white default target.
  task automatic test_reset_defaults();
    send_ticks(12);
    drain_and_settle();
  endtask

  // Field extremes at the fastest fade rate: clamped hues, full and zero saturation and
  // value, and a target equal to the current color, which must emit nothing.
  task automatic test_directed_extremes();
    write_fade_interval(8'd0);
    send_request(hfc_pkg::KIND_SET, 8'd255, 8'd255, 8'd255);
    send_ticks(3);
    send_request(hfc_pkg::KIND_SET, 8'd240, 8'd0, 8'd0);
    send_ticks(2);
    send_request(hfc_pkg::KIND_SET, 8'd239, 8'd0, 8'd0);
    send_ticks(2);
    send_request(hfc_pkg::KIND_SET, 8'd0, 8'd0, 8'd255);
    send_ticks(2);
    send_request(hfc_pkg::KIND_SET, cur_color.h, cur_color.s, cur_color.v);
    send_ticks(3);
    send_request(hfc_pkg::KIND_SET, 8'd120, 8'd128, 8'd1);
    send_ticks(2);
    drain_and_settle();
  endtask

  // With the interval at its maximum the counter saturates and nothing fades. Lowering
  // the interval by one then lets the saturated count fire on the very next tick.
  task automatic test_counter_saturation();
    write_fade_interval(8'd255);
    send_request(hfc_pkg::KIND_SET, 8'd200, 8'd255, 8'd0);
    send_ticks(270);
    drain_and_settle();
    write_fade_interval(8'd254);
    send_ticks(3);
    drain_and_settle();
  endtask

  // The receiver holds off for a long time while ticks keep coming, so the result
  // queue fills and the block must stall its request channel without losing a step.
  task automatic test_output_backpressure();
    write_fade_interval(8'd0);
    send_request(hfc_pkg::KIND_SET, (cur_color.h < 8'd120) ? hfc_pkg::HUE_MAX : 8'd0,
                 ~cur_color.s, (cur_color.v < 8'd128) ? 8'd255 : 8'd0);
    -> hold_go;
    send_ticks(40);
    drain_and_settle();
  endtask

  // Phases of random traffic. Most of it is a new target followed by a run of ticks,
  // which is what makes the current color travel through the hue sectors; the rest is
  // noise with random kinds. Each phase uses a new fade interval, mostly a short one.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_end;
    int unsigned ticks;
    logic [7:0]  interval;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: interval = 8'd255;
        1: interval = 8'($urandom_range(4, 12));
        2: interval = hfc_pkg::FADE_INTERVAL_RESET;
        default: interval = 8'($urandom_range(0, 3));
      endcase
      write_fade_interval(interval);
      // The final stretch runs with no idling on either side.
      idle_en = (sent + 100 < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
      phase_end = sent + 100;
      while (sent < phase_end && sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 6) != 0) begin
          send_request(hfc_pkg::KIND_SET, 8'($urandom), 8'($urandom), 8'($urandom));
          ticks = $urandom_range(1, 40);
          send_ticks(ticks);
          sent += ticks + 1;
        end else begin
          repeat ($urandom_range(1, 5)) begin
            send_request(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            sent++;
          end
        end
      end
      drain_and_settle();
    end
  endtask

  initial begin
    cur_color = '{8'd0, 8'd0, 8'd0};
    tgt_color = '{8'd0, 8'd0, hfc_pkg::TGT_VAL_RESET};
    tick_cnt = '0;
    fade_int = hfc_pkg::FADE_INTERVAL_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_en = 1'b1;
    test_reset_defaults();
    test_directed_extremes();
    test_counter_saturation();
    test_output_backpressure();
    test_random_traffic();
    $display("summary: %0d requests sent, %0d RGB results checked", n_requests, n_results);
    $display("summary: %0d cycles of input stall, fade intervals 0 to 255 exercised",
             n_input_stalls);
    if (err_cnt == 0 && rgb_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/hfc_pkg.sv
sv/hfc_front.sv
sv/hfc_queue.sv
sv/hfc_convert.sv
sv/hsv_fade_color_generator_core.sv
sv/hfc_checker.sv
verif/tb_top.sv
